/* rtl/core/nqp_pkg.sv */
`default_nettype none
package nqp_pkg;

   localparam int COMP_W            = 16;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int FRACTION_BITS_MAX = 30;
   localparam int EXT_W             = COMP_W + 1;
   localparam int PROD_W            = EXT_W + COMP_W;
   localparam int PSUM_W            = PROD_W + 2;
   localparam int MAG_W             = PROD_W;
   localparam int SQ_W              = 2 * MAG_W;
   localparam int S_W               = SQ_W + 2;
   localparam int T_W               = COMP_W + 1;
   localparam int V_W               = S_W + T_W;
   localparam int R_W               = SQ_W + 2 * FRACTION_BITS_MAX + 2;
   localparam int Q_W               = T_W + 1;
   localparam int LANES             = 4;

   localparam logic [Q_W-1:0]    Q_LIMIT = Q_W'(1) << (COMP_W - 1);
   localparam logic [COMP_W-1:0] SAT_POS = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] SAT_NEG = {1'b1, {(COMP_W-1){1'b0}}};

   typedef struct packed {
      logic              func;
      logic [COMP_W-1:0] a_w;
      logic [COMP_W-1:0] a_x;
      logic [COMP_W-1:0] a_y;
      logic [COMP_W-1:0] a_z;
      logic [COMP_W-1:0] b_w;
      logic [COMP_W-1:0] b_x;
      logic [COMP_W-1:0] b_y;
      logic [COMP_W-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             zero;
   } flag_type;

   typedef struct packed {
      flag_type                    flag;
      logic [S_W-1:0]              s;
      logic [LANES-1:0][R_W-1:0]   rem;
      logic [LANES-1:0][V_W-1:0]   v;
      logic [LANES-1:0][T_W-1:0]   t;
   } root_type;

endpackage
`default_nettype wire

/* rtl/core/nqp_req_if.sv */
`default_nettype none
interface nqp_req_if;
   import nqp_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [COMP_W-1:0] a_w;
   logic [COMP_W-1:0] a_x;
   logic [COMP_W-1:0] a_y;
   logic [COMP_W-1:0] a_z;
   logic [COMP_W-1:0] b_w;
   logic [COMP_W-1:0] b_x;
   logic [COMP_W-1:0] b_y;
   logic [COMP_W-1:0] b_z;
   modport source (output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   input ready);
   modport sink (input valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                 output ready);
endinterface
`default_nettype wire

/* rtl/core/nqp_rsp_if.sv */
`default_nettype none
interface nqp_rsp_if;
   import nqp_pkg::*;
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] c_w;
   logic [COMP_W-1:0] c_x;
   logic [COMP_W-1:0] c_y;
   logic [COMP_W-1:0] c_z;
   logic              zero_length;
   modport source (output valid, c_w, c_x, c_y, c_z, zero_length, input ready);
   modport sink (input valid, c_w, c_x, c_y, c_z, zero_length, output ready);
endinterface
`default_nettype wire

/* rtl/core/normalized_quaternion_product.sv */
// Normalised Hamilton product of two Q2.14 quaternions (A*B, or conj(A)*B when func is
// set), scaled to unit length with exact round-to-nearest, scalar part forced non-negative
// and results saturated to 16 bits; a zero-length product returns zeros with zero_length
// set. One beat is accepted every cycle unless rsp back-pressure stalls it; there are four
// stages for the products, sums, squares and length, one stage per quotient bit of the
// 17-bit inverse-root search, and the output register. Back-pressure on rsp stalls the
// whole pipeline, and req_bus.ready follows rsp_bus.ready combinationally.
`default_nettype none
module normalized_quaternion_product #(
   parameter int FRACTION_BITS = nqp_pkg::FRACTION_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   nqp_req_if.sink    req_bus,
   nqp_rsp_if.source  rsp_bus
);
   import nqp_pkg::*;

   logic              advance;
   req_type           req_data;
   logic              rv [T_W+1];
   root_type          rd [T_W+1];
   logic [Q_W-1:0]    q [LANES];
   logic [COMP_W-1:0] c_in [LANES];
   logic [COMP_W-1:0] c_ff [LANES];
   logic              zero_ff;
   logic              rsp_valid_ff;

   assign advance = !rsp_valid_ff || rsp_bus.ready;

   assign req_data = '{func: req_bus.func,
                       a_w: req_bus.a_w, a_x: req_bus.a_x,
                       a_y: req_bus.a_y, a_z: req_bus.a_z,
                       b_w: req_bus.b_w, b_x: req_bus.b_x,
                       b_y: req_bus.b_y, b_z: req_bus.b_z};

   nqp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_bus.valid),
      .in_data   (req_data),
      .out_valid (rv[0]),
      .out_data  (rd[0])
   );

   for (genvar g = 0; g < T_W; g++) begin : g_root
      nqp_root_step #(.BIT(T_W - 1 - g)) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rv[g]),
         .in_data   (rd[g]),
         .out_valid (rv[g+1]),
         .out_data  (rd[g+1])
      );
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         q[l] = (Q_W'(rd[T_W].t[l]) + Q_W'(1)) >> 1;
         if (rd[T_W].flag.zero) begin
            c_in[l] = '0;
         end else if (rd[T_W].flag.neg[l]) begin
            c_in[l] = (q[l] >= Q_LIMIT) ? SAT_NEG : COMP_W'(-q[l]);
         end else begin
            c_in[l] = (q[l] >= Q_LIMIT) ? SAT_POS : q[l][COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rv[T_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff    <= c_in;
         zero_ff <= rd[T_W].flag.zero;
      end
   end

   assign req_bus.ready       = advance;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.c_w         = c_ff[0];
   assign rsp_bus.c_x         = c_ff[1];
   assign rsp_bus.c_y         = c_ff[2];
   assign rsp_bus.c_z         = c_ff[3];
   assign rsp_bus.zero_length = zero_ff;

   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zero_ff |-> c_ff[0] == '0 && c_ff[1] == '0 &&
                                  c_ff[2] == '0 && c_ff[3] == '0)
      else $error("zero-length beat with non-zero components");

   a_scalar_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !c_ff[0][COMP_W-1])
      else $error("negative scalar part on output");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rv[T_W]) && $past(advance))
      else $error("output beat without a pipeline item");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rv[T_W]) && $stable(rd[T_W].t))
      else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

/* rtl/core/nqp_front.sv */
`default_nettype none
module nqp_front #(
   parameter int FRACTION_BITS = nqp_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  nqp_pkg::req_type  in_data,
   output logic              out_valid,
   output nqp_pkg::root_type out_data
);
   import nqp_pkg::*;

   logic signed [EXT_W-1:0]  ea_w, ea_x, ea_y, ea_z;
   logic signed [COMP_W-1:0] eb_w, eb_x, eb_y, eb_z;
   logic signed [PROD_W-1:0] pa_in [16];
   logic signed [PROD_W-1:0] pa_ff [16];
   logic signed [PSUM_W-1:0] p     [LANES];
   logic signed [PSUM_W-1:0] pabs  [LANES];
   logic [MAG_W-1:0]         mag_in [LANES];
   logic [MAG_W-1:0]         mag_ff [LANES];
   logic [LANES-1:0]         negb_in, negb_ff, negc_ff;
   logic [SQ_W-1:0]          sq_in [LANES];
   logic [SQ_W-1:0]          sq_ff [LANES];
   logic [S_W-1:0]           s_sum;
   root_type                 root_in, root_ff;
   logic                     va_ff, vb_ff, vc_ff, vd_ff;

   always_comb begin
      ea_w = $signed({in_data.a_w[COMP_W-1], in_data.a_w});
      ea_x = $signed({in_data.a_x[COMP_W-1], in_data.a_x});
      ea_y = $signed({in_data.a_y[COMP_W-1], in_data.a_y});
      ea_z = $signed({in_data.a_z[COMP_W-1], in_data.a_z});
      if (in_data.func) begin
         ea_x = -ea_x;
         ea_y = -ea_y;
         ea_z = -ea_z;
      end
      eb_w = $signed(in_data.b_w);
      eb_x = $signed(in_data.b_x);
      eb_y = $signed(in_data.b_y);
      eb_z = $signed(in_data.b_z);
      pa_in[0]  = ea_w * eb_w;
      pa_in[1]  = ea_x * eb_x;
      pa_in[2]  = ea_y * eb_y;
      pa_in[3]  = ea_z * eb_z;
      pa_in[4]  = ea_w * eb_x;
      pa_in[5]  = ea_x * eb_w;
      pa_in[6]  = ea_y * eb_z;
      pa_in[7]  = ea_z * eb_y;
      pa_in[8]  = ea_w * eb_y;
      pa_in[9]  = ea_x * eb_z;
      pa_in[10] = ea_y * eb_w;
      pa_in[11] = ea_z * eb_x;
      pa_in[12] = ea_w * eb_z;
      pa_in[13] = ea_x * eb_y;
      pa_in[14] = ea_y * eb_x;
      pa_in[15] = ea_z * eb_w;
   end

   always_comb begin
      p[0] = PSUM_W'(pa_ff[0])  - PSUM_W'(pa_ff[1])  - PSUM_W'(pa_ff[2])  - PSUM_W'(pa_ff[3]);
      p[1] = PSUM_W'(pa_ff[4])  + PSUM_W'(pa_ff[5])  + PSUM_W'(pa_ff[6])  - PSUM_W'(pa_ff[7]);
      p[2] = PSUM_W'(pa_ff[8])  - PSUM_W'(pa_ff[9])  + PSUM_W'(pa_ff[10]) + PSUM_W'(pa_ff[11]);
      p[3] = PSUM_W'(pa_ff[12]) + PSUM_W'(pa_ff[13]) - PSUM_W'(pa_ff[14]) + PSUM_W'(pa_ff[15]);
      for (int l = 0; l < LANES; l++) begin
         pabs[l]    = p[l][PSUM_W-1] ? -p[l] : p[l];
         mag_in[l]  = pabs[l][MAG_W-1:0];
         negb_in[l] = p[l][PSUM_W-1] ^ p[0][PSUM_W-1];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sq_in[l] = SQ_W'(mag_ff[l]) * SQ_W'(mag_ff[l]);
      end
   end

   always_comb begin
      s_sum = S_W'(sq_ff[0]) + S_W'(sq_ff[1]) + S_W'(sq_ff[2]) + S_W'(sq_ff[3]);
      root_in.flag.neg  = negc_ff;
      root_in.flag.zero = (s_sum == '0);
      root_in.s         = s_sum;
      for (int l = 0; l < LANES; l++) begin
         root_in.rem[l] = R_W'(sq_ff[l]) << (2 * FRACTION_BITS + 2);
         root_in.v[l]   = '0;
         root_in.t[l]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff   <= pa_in;
         mag_ff  <= mag_in;
         negb_ff <= negb_in;
         sq_ff   <= sq_in;
         negc_ff <= negb_ff;
         root_ff <= root_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = root_ff;

endmodule
`default_nettype wire

/* rtl/core/nqp_root_step.sv */
`default_nettype none
module nqp_root_step #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  nqp_pkg::root_type in_data,
   output logic              out_valid,
   output nqp_pkg::root_type out_data
);
   import nqp_pkg::*;

   logic [R_W-1:0] trial [LANES];
   root_type       step_in, step_ff;
   logic           valid_ff;

   always_comb begin
      step_in = in_data;
      for (int l = 0; l < LANES; l++) begin
         trial[l] = (R_W'(in_data.v[l]) << (BIT + 1)) + (R_W'(in_data.s) << (2 * BIT));
         if (in_data.rem[l] >= trial[l]) begin
            step_in.rem[l] = in_data.rem[l] - trial[l];
            step_in.v[l]   = in_data.v[l] + (V_W'(in_data.s) << BIT);
            step_in.t[l]   = in_data.t[l] | (T_W'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule
`default_nettype wire
